@@ hdl/vsrd_pkg.sv @@
// Shared types, constants and helpers for the voxel slice run-length decoder.
package vsrd_pkg;

    localparam int WORD_W    = 32;
    localparam int SIZE_W    = 9;
    localparam int COORD_W   = 8;
    localparam int LEN_W     = 17;
    localparam int MAX_DIM   = 256;
    localparam int DIVD_W    = 16;
    localparam int DIV_STEPS = DIVD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] CODE_WORD  = 32'd2;
    localparam logic [WORD_W-1:0] SLICE_WORD = 32'd6;
    localparam logic [LEN_W-1:0]  COUNT_MAX  = '1;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd3;

    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_COUNT,
        PH_VALUE
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic has_result;
        logic need_div;
        logic out_free;
    } t_dp_status;

    // Sizes of zero count as one and sizes above the maximum are clamped.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        if (s == '0) begin
            r = SIZE_W'(1);
        end else if (s > SIZE_W'(MAX_DIM)) begin
            r = SIZE_W'(MAX_DIM);
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

@@ hdl/vsrd_ctrl.sv @@
// Controller state machine that sequences acceptance, division and output loading.
module vsrd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  vsrd_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output vsrd_pkg::t_ctrl_cmd  o_cmd
);

    vsrd_pkg::t_state r_state, n_state;
    logic [vsrd_pkg::STEP_W-1:0] r_step, n_step;
    logic step_last;

    assign step_last = (r_step == vsrd_pkg::STEP_W'(vsrd_pkg::DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vsrd_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = '0;
        case (r_state)
            vsrd_pkg::S_IDLE: begin
                if (i_in_valid && i_status.has_result) begin
                    n_state = i_status.need_div ? vsrd_pkg::S_DIV : vsrd_pkg::S_LOAD;
                end
            end
            vsrd_pkg::S_DIV: begin
                n_step = r_step + vsrd_pkg::STEP_W'(1);
                if (step_last) begin
                    n_state = vsrd_pkg::S_LOAD;
                    n_step  = '0;
                end
            end
            vsrd_pkg::S_LOAD: begin
                if (i_status.out_free) begin
                    n_state = vsrd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vsrd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.div_step  = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            vsrd_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            vsrd_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            vsrd_pkg::S_LOAD: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/vsrd_dpath.sv @@
// Datapath with configuration, decode state, shift-subtract divider and output register.
module vsrd_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vsrd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vsrd_pkg::SIZE_W-1:0]         i_cfg_data,
    input  logic [vsrd_pkg::WORD_W-1:0]         i_stream_word,
    input  logic                                i_out_ready,
    input  vsrd_pkg::t_ctrl_cmd                 i_cmd,
    output vsrd_pkg::t_dp_status                o_status,
    output logic                                o_out_valid,
    output logic [vsrd_pkg::COORD_W-1:0]        o_start_x,
    output logic [vsrd_pkg::COORD_W-1:0]        o_start_y,
    output logic [vsrd_pkg::COORD_W-1:0]        o_slice_z,
    output logic [vsrd_pkg::LEN_W-1:0]          o_run_length,
    output logic [vsrd_pkg::WORD_W-1:0]         o_voxel_value,
    output logic                                o_slice_end,
    output logic                                o_matrix_end,
    output logic                                o_overflow
);

    // Configuration registers.
    logic                          r_mode;
    logic [vsrd_pkg::SIZE_W-1:0]   r_size_x, r_size_y, r_size_z;

    // Decode state.
    vsrd_pkg::t_phase              r_phase, n_phase;
    logic [vsrd_pkg::LEN_W-1:0]    r_pend, n_pend;
    logic [vsrd_pkg::LEN_W-1:0]    r_idx, n_idx;
    logic [vsrd_pkg::SIZE_W-1:0]   r_z, n_z;

    // Pending result and divider.
    logic [vsrd_pkg::COORD_W-1:0]  r_res_z;
    logic [vsrd_pkg::LEN_W-1:0]    r_res_len;
    logic [vsrd_pkg::WORD_W-1:0]   r_res_val;
    logic                          r_res_send, r_res_mend, r_res_ovf;
    logic [vsrd_pkg::DIVD_W-1:0]   r_dq;
    logic [vsrd_pkg::SIZE_W-1:0]   r_rem;
    logic                          r_out_valid;

    logic [vsrd_pkg::SIZE_W-1:0]   ex, ey, ez;
    logic [vsrd_pkg::LEN_W-1:0]    area, rem_cnt, run_len, sat_cnt, idx_inc;
    logic                          idx_ge, clip, z_wrap;
    logic [vsrd_pkg::SIZE_W:0]     z_inc;
    logic [vsrd_pkg::SIZE_W-1:0]   z_next;

    logic                          has, pos, send, mend, ovf;
    logic [vsrd_pkg::LEN_W-1:0]    len;
    logic [vsrd_pkg::WORD_W-1:0]   val;

    logic [vsrd_pkg::SIZE_W-1:0]   trial;
    logic                          trial_ge;

    assign ex      = vsrd_pkg::eff_size(r_size_x);
    assign ey      = vsrd_pkg::eff_size(r_size_y);
    assign ez      = vsrd_pkg::eff_size(r_size_z);
    assign area    = {8'd0, ex} * {8'd0, ey};
    assign idx_ge  = (r_idx >= area);
    assign idx_inc = r_idx + vsrd_pkg::LEN_W'(1);
    assign rem_cnt = idx_ge ? '0 : (area - r_idx);
    assign clip    = (r_pend > rem_cnt);
    assign run_len = clip ? rem_cnt : r_pend;
    assign sat_cnt = (|i_stream_word[vsrd_pkg::WORD_W-1:vsrd_pkg::LEN_W])
                     ? vsrd_pkg::COUNT_MAX : i_stream_word[vsrd_pkg::LEN_W-1:0];
    assign z_inc   = {1'b0, r_z} + (vsrd_pkg::SIZE_W + 1)'(1);
    assign z_wrap  = (z_inc >= {1'b0, ez});
    assign z_next  = z_wrap ? '0 : z_inc[vsrd_pkg::SIZE_W-1:0];

    always_comb begin
        has     = 1'b0;
        pos     = 1'b0;
        send    = 1'b0;
        mend    = 1'b0;
        ovf     = 1'b0;
        len     = '0;
        val     = i_stream_word;
        n_phase = r_phase;
        n_pend  = r_pend;
        n_idx   = r_idx;
        n_z     = r_z;
        if (!r_mode) begin
            n_phase = vsrd_pkg::PH_PLAIN;
            has     = 1'b1;
            if (idx_ge) begin
                send  = 1'b1;
                mend  = z_wrap;
                ovf   = 1'b1;
                n_idx = '0;
                n_z   = z_next;
            end else begin
                pos   = 1'b1;
                len   = vsrd_pkg::LEN_W'(1);
                n_idx = idx_inc;
                if (idx_inc >= area) begin
                    send  = 1'b1;
                    mend  = z_wrap;
                    n_idx = '0;
                    n_z   = z_next;
                end
            end
        end else begin
            case (r_phase)
                vsrd_pkg::PH_COUNT: begin
                    n_pend  = sat_cnt;
                    n_phase = vsrd_pkg::PH_VALUE;
                end
                vsrd_pkg::PH_VALUE: begin
                    n_phase = vsrd_pkg::PH_PLAIN;
                    if (r_pend != '0) begin
                        has   = 1'b1;
                        pos   = (run_len != '0);
                        len   = run_len;
                        ovf   = clip;
                        n_idx = r_idx + run_len;
                    end
                end
                default: begin
                    if (i_stream_word == vsrd_pkg::SLICE_WORD) begin
                        has   = 1'b1;
                        val   = '0;
                        send  = 1'b1;
                        mend  = z_wrap;
                        n_idx = '0;
                        n_z   = z_next;
                    end else if (i_stream_word == vsrd_pkg::CODE_WORD) begin
                        n_phase = vsrd_pkg::PH_COUNT;
                    end else if (idx_ge) begin
                        has = 1'b1;
                        ovf = 1'b1;
                    end else begin
                        has   = 1'b1;
                        pos   = 1'b1;
                        len   = vsrd_pkg::LEN_W'(1);
                        n_idx = idx_inc;
                    end
                end
            endcase
        end
    end

    assign trial    = {r_rem[vsrd_pkg::SIZE_W-2:0], r_dq[vsrd_pkg::DIVD_W-1]};
    assign trial_ge = (trial >= ex);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b1;
            r_size_x    <= vsrd_pkg::SIZE_W'(1);
            r_size_y    <= vsrd_pkg::SIZE_W'(1);
            r_size_z    <= vsrd_pkg::SIZE_W'(1);
            r_phase     <= vsrd_pkg::PH_PLAIN;
            r_pend      <= '0;
            r_idx       <= '0;
            r_z         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    vsrd_pkg::REG_MODE:   r_mode   <= i_cfg_data[0];
                    vsrd_pkg::REG_SIZE_X: r_size_x <= i_cfg_data;
                    vsrd_pkg::REG_SIZE_Y: r_size_y <= i_cfg_data;
                    vsrd_pkg::REG_SIZE_Z: r_size_z <= i_cfg_data;
                    default: r_mode <= r_mode;
                endcase
            end
            if (i_cmd.accept) begin
                r_phase <= n_phase;
                r_pend  <= n_pend;
                r_idx   <= n_idx;
                r_z     <= n_z;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && has) begin
            r_res_z    <= r_z[vsrd_pkg::COORD_W-1:0];
            r_res_len  <= len;
            r_res_val  <= val;
            r_res_send <= send;
            r_res_mend <= mend;
            r_res_ovf  <= ovf;
            r_dq       <= pos ? r_idx[vsrd_pkg::DIVD_W-1:0] : '0;
            r_rem      <= '0;
        end else if (i_cmd.div_step) begin
            r_dq  <= {r_dq[vsrd_pkg::DIVD_W-2:0], trial_ge};
            r_rem <= trial_ge ? (trial - ex) : trial;
        end
        if (i_cmd.load_out) begin
            o_start_x     <= r_rem[vsrd_pkg::COORD_W-1:0];
            o_start_y     <= r_dq[vsrd_pkg::COORD_W-1:0];
            o_slice_z     <= r_res_z;
            o_run_length  <= r_res_len;
            o_voxel_value <= r_res_val;
            o_slice_end   <= r_res_send;
            o_matrix_end  <= r_res_mend;
            o_overflow    <= r_res_ovf;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status.has_result = has;
    assign o_status.need_div   = pos;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

endmodule

@@ hdl/voxel_slice_rle_decoder_core.sv @@
// Top level of the voxel slice run-length decoder.
//
// The input channel takes one 32-bit stream word per transaction. The output
// channel delivers at most one run descriptor per input word: start x and y,
// slice z, run length, voxel value and the slice end, matrix end and overflow
// flags. Code and count words, and runs with a count of zero, give nothing.
// The configuration port writes the mode and the three matrix sizes; it must be
// written only while the decoder is idle; the block does not enforce this.
// A word is decoded at the edge that accepts it. A word that yields a voxel or
// run with a position passes through the one-bit-per-cycle divider that splits
// the slice index into x and y, and then the output register load. Slice
// markers and dropped voxels skip the divider and go straight to the load. The
// next word is accepted once the result has been loaded, so the input is held
// off while a result is divided or waits for the output register; a code or
// count word is accepted without leaving idle.
// Reset returns the decoder to compressed mode with all sizes one, the first
// slice, index zero and no pending result. When the receiver stalls, the
// result stays in the output register and one more result may wait behind it;
// input is then held off until the output register frees up.
module voxel_slice_rle_decoder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vsrd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vsrd_pkg::SIZE_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [vsrd_pkg::WORD_W-1:0]         i_stream_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [vsrd_pkg::COORD_W-1:0]        o_start_x,
    output logic [vsrd_pkg::COORD_W-1:0]        o_start_y,
    output logic [vsrd_pkg::COORD_W-1:0]        o_slice_z,
    output logic [vsrd_pkg::LEN_W-1:0]          o_run_length,
    output logic [vsrd_pkg::WORD_W-1:0]         o_voxel_value,
    output logic                                o_slice_end,
    output logic                                o_matrix_end,
    output logic                                o_overflow
);

    vsrd_pkg::t_ctrl_cmd  cmd;
    vsrd_pkg::t_dp_status status;

    vsrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    vsrd_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_stream_word (i_stream_word),
        .i_out_ready   (i_out_ready),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_start_x     (o_start_x),
        .o_start_y     (o_start_y),
        .o_slice_z     (o_slice_z),
        .o_run_length  (o_run_length),
        .o_voxel_value (o_voxel_value),
        .o_slice_end   (o_slice_end),
        .o_matrix_end  (o_matrix_end),
        .o_overflow    (o_overflow)
    );

endmodule

@@ hdl/vsrd_checker.sv @@
// Port-level checker for the decoder, bound to the top level.
module vsrd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [vsrd_pkg::COORD_W-1:0]        o_start_x,
    input logic [vsrd_pkg::COORD_W-1:0]        o_start_y,
    input logic [vsrd_pkg::COORD_W-1:0]        o_slice_z,
    input logic [vsrd_pkg::LEN_W-1:0]          o_run_length,
    input logic [vsrd_pkg::WORD_W-1:0]         o_voxel_value,
    input logic                                o_slice_end,
    input logic                                o_matrix_end,
    input logic                                o_overflow
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_start_x) && $stable(o_start_y)
            && $stable(o_slice_z) && $stable(o_run_length) && $stable(o_voxel_value)
            && $stable(o_slice_end) && $stable(o_matrix_end) && $stable(o_overflow))
        else $error("output payload changed while stalled");

    a_matrix_end_on_slice_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_matrix_end |-> o_slice_end)
        else $error("matrix end without slice end");

    a_empty_run_at_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_run_length == '0) |-> (o_start_x == '0) && (o_start_y == '0))
        else $error("empty run with nonzero start position");

endmodule

bind voxel_slice_rle_decoder_core vsrd_checker u_vsrd_checker (.*);

@@ bench/voxel_slice_rle_decoder_core_tb.sv @@
// Self-checking testbench for the voxel slice run-length decoder core.
module voxel_slice_rle_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [vsrd_pkg::COORD_W-1:0] start_x;
        logic [vsrd_pkg::COORD_W-1:0] start_y;
        logic [vsrd_pkg::COORD_W-1:0] slice_z;
        logic [vsrd_pkg::LEN_W-1:0]   run_length;
        logic [vsrd_pkg::WORD_W-1:0]  voxel_value;
        logic                         slice_end;
        logic                         matrix_end;
        logic                         overflow;
    } t_run_desc;

    typedef enum {
        SEQ_RUN,
        SEQ_VOXEL,
        SEQ_SLICE,
        SEQ_NOISE
    } t_stim_kind;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [vsrd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [vsrd_pkg::SIZE_W-1:0]    i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [vsrd_pkg::WORD_W-1:0]    i_stream_word = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [vsrd_pkg::COORD_W-1:0]   o_start_x;
    logic [vsrd_pkg::COORD_W-1:0]   o_start_y;
    logic [vsrd_pkg::COORD_W-1:0]   o_slice_z;
    logic [vsrd_pkg::LEN_W-1:0]     o_run_length;
    logic [vsrd_pkg::WORD_W-1:0]    o_voxel_value;
    logic                           o_slice_end;
    logic                           o_matrix_end;
    logic                           o_overflow;

    logic                        cfg_compressed = 1'b1;
    logic [vsrd_pkg::SIZE_W-1:0] cfg_sx = 9'd1;
    logic [vsrd_pkg::SIZE_W-1:0] cfg_sy = 9'd1;
    logic [vsrd_pkg::SIZE_W-1:0] cfg_sz = 9'd1;
    vsrd_pkg::t_phase            dec_phase = vsrd_pkg::PH_PLAIN;
    logic [vsrd_pkg::LEN_W-1:0]  dec_count = '0;
    logic [vsrd_pkg::LEN_W-1:0]  dec_index = '0;
    logic [vsrd_pkg::SIZE_W-1:0] dec_z = '0;

    t_run_desc   expected_runs[$];
    t_run_desc   exp_run;
    int unsigned fail_count = 0;

    bit          tx_gaps = 1'b0;
    int unsigned burst_left = 0;
    bit          rx_stalls = 1'b0;
    bit          rx_busy = 1'b0;
    int unsigned rx_run = 0;
    int unsigned stall_request = 0;
    int unsigned stall_left = 0;

    always #4 i_clk = ~i_clk;

    voxel_slice_rle_decoder_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_stream_word (i_stream_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_start_x     (o_start_x),
        .o_start_y     (o_start_y),
        .o_slice_z     (o_slice_z),
        .o_run_length  (o_run_length),
        .o_voxel_value (o_voxel_value),
        .o_slice_end   (o_slice_end),
        .o_matrix_end  (o_matrix_end),
        .o_overflow    (o_overflow)
    );

    function automatic int unsigned clamp_size(input logic [vsrd_pkg::SIZE_W-1:0] s);
        if (s == '0) begin
            return 1;
        end
        if (s > vsrd_pkg::MAX_DIM) begin
            return vsrd_pkg::MAX_DIM;
        end
        return 32'(s);
    endfunction

    // Moves to the next slice and reports whether the matrix is complete.
    function automatic bit advance_slice();
        dec_index = '0;
        if (dec_z + 1 >= clamp_size(cfg_sz)) begin
            dec_z = '0;
            return 1'b1;
        end
        dec_z = dec_z + 1'b1;
        return 1'b0;
    endfunction

    function automatic t_run_desc make_run(input int unsigned idx, input bit has_pos,
                                           input int unsigned len,
                                           input logic [vsrd_pkg::WORD_W-1:0] value,
                                           input bit s_end, input bit ovf);
        t_run_desc   r;
        int unsigned sx;
        sx = clamp_size(cfg_sx);
        r.start_x     = has_pos ? vsrd_pkg::COORD_W'(idx % sx) : '0;
        r.start_y     = has_pos ? vsrd_pkg::COORD_W'(idx / sx) : '0;
        r.slice_z     = vsrd_pkg::COORD_W'(dec_z);
        r.run_length  = vsrd_pkg::LEN_W'(len);
        r.voxel_value = value;
        r.slice_end   = s_end;
        r.matrix_end  = 1'b0;
        r.overflow    = ovf;
        return r;
    endfunction

    function automatic void decode_word(input logic [vsrd_pkg::WORD_W-1:0] w);
        int unsigned area;
        int unsigned remain;
        int unsigned len;
        bit          ovf;
        t_run_desc   r;
        area = clamp_size(cfg_sx) * clamp_size(cfg_sy);
        if (!cfg_compressed) begin
            dec_phase = vsrd_pkg::PH_PLAIN;
            if (dec_index >= area) begin
                r = make_run(0, 1'b0, 0, w, 1'b1, 1'b1);
                r.matrix_end = advance_slice();
            end else begin
                r = make_run(32'(dec_index), 1'b1, 1, w, 1'b0, 1'b0);
                dec_index = dec_index + 1'b1;
                if (dec_index >= area) begin
                    r.slice_end  = 1'b1;
                    r.matrix_end = advance_slice();
                end
            end
            expected_runs.push_back(r);
            return;
        end
        case (dec_phase)
            vsrd_pkg::PH_COUNT: begin
                dec_count = (w > vsrd_pkg::COUNT_MAX) ? vsrd_pkg::COUNT_MAX
                                                      : w[vsrd_pkg::LEN_W-1:0];
                dec_phase = vsrd_pkg::PH_VALUE;
            end
            vsrd_pkg::PH_VALUE: begin
                dec_phase = vsrd_pkg::PH_PLAIN;
                if (dec_count != '0) begin
                    remain = (dec_index >= area) ? 0 : area - dec_index;
                    len = 32'(dec_count);
                    ovf = 1'b0;
                    if (len > remain) begin
                        len = remain;
                        ovf = 1'b1;
                    end
                    r = make_run(32'(dec_index), len != 0, len, w, 1'b0, ovf);
                    dec_index = vsrd_pkg::LEN_W'(dec_index + len);
                    expected_runs.push_back(r);
                end
            end
            default: begin
                if (w == vsrd_pkg::SLICE_WORD) begin
                    r = make_run(0, 1'b0, 0, '0, 1'b1, 1'b0);
                    r.matrix_end = advance_slice();
                    expected_runs.push_back(r);
                end else if (w == vsrd_pkg::CODE_WORD) begin
                    dec_phase = vsrd_pkg::PH_COUNT;
                end else if (dec_index >= area) begin
                    expected_runs.push_back(make_run(0, 1'b0, 0, w, 1'b0, 1'b1));
                end else begin
                    expected_runs.push_back(make_run(32'(dec_index), 1'b1, 1, w,
                                                     1'b0, 1'b0));
                    dec_index = dec_index + 1'b1;
                end
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [vsrd_pkg::WORD_W-1:0] want,
                               input logic [vsrd_pkg::WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_runs.size() == 0) begin
                $error("result with no expectation: voxel_value 0x%0h", o_voxel_value);
                fail_count++;
            end else begin
                exp_run = expected_runs.pop_front();
                check_field("start_x", 32'(exp_run.start_x), 32'(o_start_x));
                check_field("start_y", 32'(exp_run.start_y), 32'(o_start_y));
                check_field("slice_z", 32'(exp_run.slice_z), 32'(o_slice_z));
                check_field("run_length", 32'(exp_run.run_length), 32'(o_run_length));
                check_field("voxel_value", exp_run.voxel_value, o_voxel_value);
                check_field("slice_end", 32'(exp_run.slice_end), 32'(o_slice_end));
                check_field("matrix_end", 32'(exp_run.matrix_end), 32'(o_matrix_end));
                check_field("overflow", 32'(exp_run.overflow), 32'(o_overflow));
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_request != 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!rx_stalls) begin
            i_out_ready <= 1'b1;
        end else begin
            if (rx_run == 0) begin
                rx_busy = !rx_busy;
                rx_run = rx_busy ? $urandom_range(1, 12) : $urandom_range(1, 40);
            end
            rx_run--;
            i_out_ready <= !rx_busy;
        end
    end

    task automatic send_word(input logic [vsrd_pkg::WORD_W-1:0] w);
        int unsigned gap;
        gap = 0;
        if (tx_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 8);
            end
            burst_left--;
        end
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_stream_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        decode_word(w);
    endtask

    task automatic send_run(input logic [vsrd_pkg::WORD_W-1:0] count,
                            input logic [vsrd_pkg::WORD_W-1:0] value);
        send_word(vsrd_pkg::CODE_WORD);
        send_word(count);
        send_word(value);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_runs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [vsrd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vsrd_pkg::SIZE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            vsrd_pkg::REG_MODE:   cfg_compressed = value[0];
            vsrd_pkg::REG_SIZE_X: cfg_sx = value;
            vsrd_pkg::REG_SIZE_Y: cfg_sy = value;
            default:              cfg_sz = value;
        endcase
    endtask

    task automatic set_geometry(input bit mode, input logic [vsrd_pkg::SIZE_W-1:0] sx,
                                input logic [vsrd_pkg::SIZE_W-1:0] sy,
                                input logic [vsrd_pkg::SIZE_W-1:0] sz);
        settle();
        write_reg(vsrd_pkg::REG_MODE, vsrd_pkg::SIZE_W'(mode));
        write_reg(vsrd_pkg::REG_SIZE_X, sx);
        write_reg(vsrd_pkg::REG_SIZE_Y, sy);
        write_reg(vsrd_pkg::REG_SIZE_Z, sz);
    endtask

    task automatic send_random_sequence();
        t_stim_kind  kind;
        int unsigned pick;
        int unsigned area;
        logic [vsrd_pkg::WORD_W-1:0] count;
        logic [vsrd_pkg::WORD_W-1:0] value;
        area = clamp_size(cfg_sx) * clamp_size(cfg_sy);
        pick = $urandom_range(0, 99);
        kind = (pick < 45) ? SEQ_RUN : (pick < 75) ? SEQ_VOXEL :
               (pick < 90) ? SEQ_SLICE : SEQ_NOISE;
        case (kind)
            SEQ_RUN: begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    count = '0;
                end else if (pick == 1) begin
                    count = $urandom();
                end else if (pick < 5) begin
                    count = area + $urandom_range(0, 4);
                end else begin
                    count = $urandom_range(1, area);
                end
                if ($urandom_range(0, 9) == 0) begin
                    value = $urandom_range(0, 1) ? vsrd_pkg::CODE_WORD
                                                 : vsrd_pkg::SLICE_WORD;
                end else begin
                    value = $urandom();
                end
                send_run(count, value);
            end
            SEQ_VOXEL: send_word($urandom());
            SEQ_SLICE: send_word(vsrd_pkg::SLICE_WORD);
            default:   send_word($urandom_range(0, 7));
        endcase
    endtask

    task automatic test_reset_state();
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        send_word(32'h1234_5678);
        send_word(32'hFFFF_FFFF);
        send_word(vsrd_pkg::SLICE_WORD);
    endtask

    task automatic test_compressed_cases();
        set_geometry(1'b1, 9'd4, 9'd3, 9'd2);
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        send_word(32'h8000_0001);
        send_run(32'd5, 32'hA5A5_A5A5);
        send_run(32'd0, 32'h5A5A_5A5A);
        send_run(32'hFFFF_FFFF, 32'h0000_0000);
        send_word(32'h0000_0001);
        send_run(32'd3, vsrd_pkg::SLICE_WORD);
        send_word(vsrd_pkg::SLICE_WORD);
        send_word(vsrd_pkg::SLICE_WORD);
        send_word(vsrd_pkg::CODE_WORD);
    endtask

    task automatic test_raw_cases();
        set_geometry(1'b0, 9'd2, 9'd2, 9'd2);
        repeat (3) send_word($urandom());
        settle();
        write_reg(vsrd_pkg::REG_SIZE_X, 9'd1);
        write_reg(vsrd_pkg::REG_SIZE_Y, 9'd1);
        send_word($urandom());
        settle();
        write_reg(vsrd_pkg::REG_SIZE_Z, 9'd1);
        send_word($urandom());
    endtask

    task automatic test_size_extremes();
        set_geometry(1'b1, 9'd511, 9'd0, 9'd511);
        send_run(32'd200, $urandom());
        send_word(32'h7FFF_FFFF);
        send_run(32'd100, $urandom());
        repeat (256) send_word(vsrd_pkg::SLICE_WORD);
        set_geometry(1'b1, 9'd256, 9'd256, 9'd0);
        send_run(32'd65536, $urandom());
        send_run(32'd1, $urandom());
        send_word(vsrd_pkg::SLICE_WORD);
        repeat (3) begin
            send_run($urandom_range(0, 65535), $urandom());
            send_word($urandom());
            send_word(vsrd_pkg::SLICE_WORD);
        end
        set_geometry(1'b1, 9'd0, 9'd0, 9'd0);
        send_word($urandom());
        send_word($urandom());
        send_word(vsrd_pkg::SLICE_WORD);
    endtask

    task automatic test_random_compressed();
        for (int p = 0; p < 6; p++) begin
            if (p == 0) begin
                set_geometry(1'b1, 9'd1, 9'd1, 9'd1);
            end else begin
                set_geometry(1'b1, vsrd_pkg::SIZE_W'($urandom_range(1, 8)),
                             vsrd_pkg::SIZE_W'($urandom_range(1, 8)),
                             vsrd_pkg::SIZE_W'($urandom_range(1, 4)));
            end
            tx_gaps = p[0];
            rx_stalls = (p % 3) != 0;
            repeat (5) send_random_sequence();
        end
    endtask

    task automatic test_random_raw();
        for (int p = 0; p < 3; p++) begin
            if (p == 0) begin
                set_geometry(1'b0, 9'd1, 9'd1, 9'd1);
            end else begin
                set_geometry(1'b0, vsrd_pkg::SIZE_W'($urandom_range(1, 6)),
                             vsrd_pkg::SIZE_W'($urandom_range(1, 6)),
                             vsrd_pkg::SIZE_W'($urandom_range(1, 3)));
            end
            tx_gaps = p != 1;
            rx_stalls = p != 2;
            repeat (10) send_word($urandom());
        end
    endtask

    task automatic test_output_hold_off();
        set_geometry(1'b1, 9'd5, 9'd5, 9'd3);
        tx_gaps = 1'b0;
        rx_stalls = 1'b1;
        stall_request = 400;
        repeat (20) send_random_sequence();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_compressed_cases();
        test_raw_cases();
        test_size_extremes();
        test_random_compressed();
        test_random_raw();
        test_output_hold_off();
        settle();
        if (fail_count == 0) begin
            $display("** voxel_slice_rle_decoder_core: PASSED **");
        end else begin
            $display("** voxel_slice_rle_decoder_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** voxel_slice_rle_decoder_core: FAILED **");
        $finish;
    end

endmodule
